/* design/rma_pkg.sv */
// Shared types and constants of the residue number system ALU.
package rma_pkg;

   localparam int LANES_DEFAULT        = 4;
   localparam int RESIDUE_BITS_DEFAULT = 32;
   localparam int NUM_CHANNELS         = 4;
   localparam int CSR_INDEX_BITS       = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MODULUS_0 = 2'd0,
      REG_MODULUS_1 = 2'd1,
      REG_MODULUS_2 = 2'd2,
      REG_MODULUS_3 = 2'd3
   } csr_index_type;

   localparam logic [63:0] MODULUS_RESET [NUM_CHANNELS] = '{
      64'd4294967291, 64'd4294967279, 64'd4294967231, 64'd4294967197
   };

endpackage

/* design/rma_lane.sv */
// One residue channel: pipelined operand reduction, shift-add modular multiply and result select.
module rma_lane #(
   parameter int RESIDUE_BITS = rma_pkg::RESIDUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     enable,
   input  rma_pkg::op_type          op_in,
   input  logic [RESIDUE_BITS-1:0]  a_in,
   input  logic [RESIDUE_BITS-1:0]  b_in,
   input  logic [RESIDUE_BITS-1:0]  modulus,
   output logic [RESIDUE_BITS-1:0]  result
);

   localparam int W = RESIDUE_BITS;

   logic [W-1:0]    ra_ff  [W];
   logic [W-1:0]    rb_ff  [W];
   logic [W-1:0]    da_ff  [W];
   logic [W-1:0]    db_ff  [W];
   rma_pkg::op_type opr_ff [W];

   logic [W-1:0]    acc_ff [W];
   logic [W-1:0]    x_ff   [W];
   logic [W-1:0]    y_ff   [W];
   logic [W-1:0]    as_ff  [W];
   rma_pkg::op_type opm_ff [W];

   logic [W-1:0]    res_ff;
   logic [W-1:0]    res_in;
   logic [W:0]      mod_ext;

   assign mod_ext = {1'b0, modulus};

   genvar s;
   generate
      for (s = 0; s < W; s++) begin : g_red
         logic [W-1:0]    ra_prev, rb_prev, da_prev, db_prev;
         rma_pkg::op_type op_prev;
         logic [W:0]      ta, tb;
         logic [W-1:0]    ra_in, rb_in;

         if (s == 0) begin : g_first
            assign ra_prev = '0;
            assign rb_prev = '0;
            assign da_prev = a_in;
            assign db_prev = b_in;
            assign op_prev = op_in;
         end else begin : g_next
            assign ra_prev = ra_ff[s-1];
            assign rb_prev = rb_ff[s-1];
            assign da_prev = da_ff[s-1];
            assign db_prev = db_ff[s-1];
            assign op_prev = opr_ff[s-1];
         end

         always_comb begin
            ta = {ra_prev, da_prev[W-1-s]};
            tb = {rb_prev, db_prev[W-1-s]};
            if (ta >= mod_ext) begin
               ta = ta - mod_ext;
            end
            if (tb >= mod_ext) begin
               tb = tb - mod_ext;
            end
            ra_in = ta[W-1:0];
            rb_in = tb[W-1:0];
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               ra_ff[s]  <= ra_in;
               rb_ff[s]  <= rb_in;
               da_ff[s]  <= da_prev;
               db_ff[s]  <= db_prev;
               opr_ff[s] <= op_prev;
            end
         end
      end

      for (s = 0; s < W; s++) begin : g_mul
         logic [W-1:0]    acc_prev, x_prev, y_prev, as_prev;
         rma_pkg::op_type op_prev;
         logic [W:0]      d, t;
         logic [W-1:0]    acc_in;

         if (s == 0) begin : g_first
            logic [W:0] sum;
            always_comb begin
               sum = '0;
               case (opr_ff[W-1])
                  rma_pkg::OP_SUB: begin
                     if (ra_ff[W-1] >= rb_ff[W-1]) begin
                        sum = {1'b0, ra_ff[W-1]} - {1'b0, rb_ff[W-1]};
                     end else begin
                        sum = {1'b0, ra_ff[W-1]} + mod_ext - {1'b0, rb_ff[W-1]};
                     end
                  end
                  default: begin
                     sum = {1'b0, ra_ff[W-1]} + {1'b0, rb_ff[W-1]};
                     if (sum >= mod_ext) begin
                        sum = sum - mod_ext;
                     end
                  end
               endcase
            end
            assign acc_prev = '0;
            assign x_prev   = ra_ff[W-1];
            assign y_prev   = rb_ff[W-1];
            assign as_prev  = sum[W-1:0];
            assign op_prev  = opr_ff[W-1];
         end else begin : g_next
            assign acc_prev = acc_ff[s-1];
            assign x_prev   = x_ff[s-1];
            assign y_prev   = y_ff[s-1];
            assign as_prev  = as_ff[s-1];
            assign op_prev  = opm_ff[s-1];
         end

         always_comb begin
            d = {acc_prev, 1'b0};
            if (d >= mod_ext) begin
               d = d - mod_ext;
            end
            t = d;
            if (y_prev[W-1-s]) begin
               t = d + {1'b0, x_prev};
               if (t >= mod_ext) begin
                  t = t - mod_ext;
               end
            end
            acc_in = t[W-1:0];
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               acc_ff[s] <= acc_in;
               x_ff[s]   <= x_prev;
               y_ff[s]   <= y_prev;
               as_ff[s]  <= as_prev;
               opm_ff[s] <= op_prev;
            end
         end
      end
   endgenerate

   always_comb begin
      res_in = '0;
      if (modulus >= W'(2)) begin
         case (opm_ff[W-1])
            rma_pkg::OP_ADD: res_in = as_ff[W-1];
            rma_pkg::OP_SUB: res_in = as_ff[W-1];
            rma_pkg::OP_MUL: res_in = acc_ff[W-1];
            default:         res_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

/* design/rns_modular_alu_top.sv */
// Top level of the residue number system ALU: modulus registers, parallel lanes and output merge.
//
// Usage: a request word carries an operation (add, subtract, multiply) and one
// operand pair per residue channel; it is accepted on a rising edge with
// req_valid high and req_stall low. Each response word carries the reduced
// residue of every channel and is taken on an edge with rsp_valid high and
// rsp_stall low. The moduli are written through the csr_ port while idle.
// Pipeline order: one remainder bit per stage reduces the operands, one multiplier
// bit per stage runs the shift-add multiply, then the lane result and the output
// register. Throughput is one word per cycle while the receiver does not stall;
// all lanes advance together as one pipeline.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// req_stall rises; an empty output register lets the pipeline move on.
// Reset clears all pipeline valid bits and loads the default moduli.
module rns_modular_alu_top #(
   parameter int LANES        = rma_pkg::LANES_DEFAULT,
   parameter int RESIDUE_BITS = rma_pkg::RESIDUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_operation,
   input  logic [RESIDUE_BITS-1:0]            req_a_lane0,
   input  logic [RESIDUE_BITS-1:0]            req_b_lane0,
   input  logic [RESIDUE_BITS-1:0]            req_a_lane1,
   input  logic [RESIDUE_BITS-1:0]            req_b_lane1,
   input  logic [RESIDUE_BITS-1:0]            req_a_lane2,
   input  logic [RESIDUE_BITS-1:0]            req_b_lane2,
   input  logic [RESIDUE_BITS-1:0]            req_a_lane3,
   input  logic [RESIDUE_BITS-1:0]            req_b_lane3,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [RESIDUE_BITS-1:0]            rsp_result_lane0,
   output logic [RESIDUE_BITS-1:0]            rsp_result_lane1,
   output logic [RESIDUE_BITS-1:0]            rsp_result_lane2,
   output logic [RESIDUE_BITS-1:0]            rsp_result_lane3,
   input  logic                               csr_write,
   input  logic [rma_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [RESIDUE_BITS-1:0]            csr_data
);

   localparam int W   = RESIDUE_BITS;
   localparam int LAT = 2 * W + 1;
   localparam int NCH = rma_pkg::NUM_CHANNELS;

   logic [W-1:0] modulus_ff [NCH];
   logic [W-1:0] a_bus [NCH];
   logic [W-1:0] b_bus [NCH];
   logic [W-1:0] lane_res [NCH];
   logic [W-1:0] out_ff [NCH];
   logic [LAT-1:0] valid_ff;
   logic [LAT-1:0] valid_in;
   logic           rsp_valid_ff;
   logic           advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign a_bus[0] = req_a_lane0;
   assign b_bus[0] = req_b_lane0;
   assign a_bus[1] = req_a_lane1;
   assign b_bus[1] = req_b_lane1;
   assign a_bus[2] = req_a_lane2;
   assign b_bus[2] = req_b_lane2;
   assign a_bus[3] = req_a_lane3;
   assign b_bus[3] = req_b_lane3;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            modulus_ff[i] <= rma_pkg::MODULUS_RESET[i][W-1:0];
         end
      end else if (csr_write) begin
         case (rma_pkg::csr_index_type'(csr_index))
            rma_pkg::REG_MODULUS_0: modulus_ff[0] <= csr_data;
            rma_pkg::REG_MODULUS_1: modulus_ff[1] <= csr_data;
            rma_pkg::REG_MODULUS_2: modulus_ff[2] <= csr_data;
            rma_pkg::REG_MODULUS_3: modulus_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   genvar j;
   generate
      for (j = 0; j < NCH; j++) begin : g_lane
         if (j < LANES) begin : g_on
            rma_lane #(.RESIDUE_BITS(RESIDUE_BITS)) u_lane (
               .clock   (clock),
               .enable  (advance),
               .op_in   (rma_pkg::op_type'(req_operation)),
               .a_in    (a_bus[j]),
               .b_in    (b_bus[j]),
               .modulus (modulus_ff[j]),
               .result  (lane_res[j])
            );
         end else begin : g_off
            assign lane_res[j] = '0;
         end
      end
   endgenerate

   assign valid_in = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NCH; i++) begin
            out_ff[i] <= lane_res[i];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_lane0 = out_ff[0];
   assign rsp_result_lane1 = out_ff[1];
   assign rsp_result_lane2 = out_ff[2];
   assign rsp_result_lane3 = out_ff[3];

endmodule

/* dv/rns_modular_alu_top_tb.sv */
// Self-checking testbench of the residue number system ALU: directed and random words.
module rns_modular_alu_top_tb;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] a [4];
      logic [31:0] b [4];
   } alu_word_type;

   typedef struct {
      logic [31:0] r [4];
   } residue_set_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_operation = 0;
   logic [31:0] req_a_lane0 = 0, req_b_lane0 = 0, req_a_lane1 = 0, req_b_lane1 = 0;
   logic [31:0] req_a_lane2 = 0, req_b_lane2 = 0, req_a_lane3 = 0, req_b_lane3 = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [31:0] rsp_result_lane0, rsp_result_lane1, rsp_result_lane2, rsp_result_lane3;
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   logic [31:0]     moduli [4];
   residue_set_type expected_residues [$];
   int              errors = 0;
   int              words_sent = 0;
   int              words_checked = 0;
   bit              hold_off = 0;

   rns_modular_alu_top uut (.*);

   always #10 clock = ~clock;

   function automatic logic [31:0] lane_residue(logic [1:0] op, logic [31:0] a,
                                                logic [31:0] b, logic [31:0] m);
      logic [63:0] wide;
      logic [31:0] r;
      if (m < 2) return 32'd0;
      case (op)
         rma_pkg::OP_ADD: wide = {32'd0, a} + {32'd0, b};
         rma_pkg::OP_SUB: begin
            if (a >= b) return (a - b) % m;
            r = (b - a) % m;
            return (r == 0) ? 32'd0 : m - r;
         end
         rma_pkg::OP_MUL: wide = {32'd0, a} * {32'd0, b};
         default: return 32'd0;
      endcase
      return 32'(wide % {32'd0, m});
   endfunction

   task automatic write_modulus(rma_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      moduli[idx] = value;
   endtask

   task automatic send_word(alu_word_type w);
      residue_set_type e;
      int idle;
      idle = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
      if (idle != 0) begin
         req_valid <= 0;
         repeat (idle) @(posedge clock);
      end
      for (int j = 0; j < 4; j++) e.r[j] = lane_residue(w.op, w.a[j], w.b[j], moduli[j]);
      req_valid <= 1;
      req_operation <= w.op;
      {req_a_lane0, req_b_lane0} <= {w.a[0], w.b[0]};
      {req_a_lane1, req_b_lane1} <= {w.a[1], w.b[1]};
      {req_a_lane2, req_b_lane2} <= {w.a[2], w.b[2]};
      {req_a_lane3, req_b_lane3} <= {w.a[3], w.b[3]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_residues.push_back(e);
      words_sent++;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_residues.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand(logic [31:0] m);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return m - 1;
         3: return $urandom_range(0, 3) + m;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      alu_word_type w;
      logic [31:0] edges [4] = '{32'd0, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      for (int op = 0; op < 4; op++) begin
         for (int k = 0; k < 4; k++) begin
            w.op = 2'(op);
            for (int j = 0; j < 4; j++) begin
               w.a[j] = edges[k];
               w.b[j] = edges[(k + j + 1) % 4];
            end
            send_word(w);
         end
      end
   endtask

   task automatic test_random(int count);
      alu_word_type w;
      for (int n = 0; n < count; n++) begin
         w.op = ($urandom_range(0, 19) == 0) ? 2'(rma_pkg::OP_NOP) : 2'($urandom_range(0, 2));
         for (int j = 0; j < 4; j++) begin
            w.a[j] = random_operand(moduli[j]);
            w.b[j] = random_operand(moduli[j]);
         end
         send_word(w);
      end
   endtask

   task automatic test_moduli_extremes;
      drain();
      write_modulus(rma_pkg::REG_MODULUS_0, 32'd0);
      write_modulus(rma_pkg::REG_MODULUS_1, 32'd1);
      write_modulus(rma_pkg::REG_MODULUS_2, 32'd2);
      write_modulus(rma_pkg::REG_MODULUS_3, 32'hFFFF_FFFF);
      test_directed();
      test_random(200);
   endtask

   task automatic test_moduli_random;
      drain();
      write_modulus(rma_pkg::REG_MODULUS_0, $urandom_range(3, 1000));
      write_modulus(rma_pkg::REG_MODULUS_1, $urandom);
      write_modulus(rma_pkg::REG_MODULUS_2, 32'd65537);
      write_modulus(rma_pkg::REG_MODULUS_3, $urandom | 32'h8000_0000);
      test_random(300);
   endtask

   task automatic test_backpressure;
      hold_off = 1;
      test_random(150);
      hold_off = 0;
   endtask

   always @(posedge clock) begin
      residue_set_type e;
      logic [31:0] got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_lane0, rsp_result_lane1, rsp_result_lane2, rsp_result_lane3};
         if (expected_residues.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h %h %h %h", $time,
                     got[0], got[1], got[2], got[3]);
            errors++;
         end else begin
            e = expected_residues.pop_front();
            for (int j = 0; j < 4; j++)
               if (got[j] !== e.r[j]) begin
                  $display("%0t: lane %0d expected %h actual %h", $time, j, e.r[j], got[j]);
                  errors++;
               end
            words_checked++;
         end
      end
   end

   initial begin
      int wait_cycles;
      int long_done;
      long_done = 0;
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (hold_off && !long_done) begin
            long_done = 1;
            rsp_stall <= 1;
            repeat (200) @(posedge clock);
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
         if (wait_cycles != 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   initial begin
      #20_000_000;
      $display("rns_modular_alu_top regression: fail");
      $finish;
   end

   initial begin
      for (int j = 0; j < 4; j++) moduli[j] = rma_pkg::MODULUS_RESET[j][31:0];
      repeat (7) @(posedge clock);
      reset <= 0;
      test_directed();
      test_random(400);
      test_backpressure();
      test_moduli_extremes();
      test_moduli_random();
      drain();
      $display("Sent %0d words and checked %0d across reset, extreme and random moduli.",
               words_sent, words_checked);
      if (errors == 0) begin
         $display("rns_modular_alu_top regression: pass");
      end else begin
         $display("rns_modular_alu_top regression: fail");
      end
      $finish;
   end
endmodule

/* sim.f */
design/rma_pkg.sv
design/rma_lane.sv
design/rns_modular_alu_top.sv
dv/rns_modular_alu_top_tb.sv
